@@ design/sgod_pkg.sv @@
// Shared types and constants for the spectral growth onset detector.
// No dependencies.
`default_nettype none
package sgod_pkg;
   localparam int MaxBands = 64;
   localparam int BandW = $clog2(MaxBands);
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 32;

   localparam logic [CsrIdxW-1:0] CSR_LO_THRESH  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_HI_THRESH  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_MIN_ENERGY = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_FIRST_BAND = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_LAST_BAND  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_HOLD       = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_DECAY      = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_DEBOUNCE   = 3'd7;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_DIV, ST_UPDATE, ST_OUT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic div_start;
      logic update;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_done;
   } sts_type;
endpackage
`default_nettype wire

@@ design/sgod_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module sgod_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

@@ design/sgod_ctrl.sv @@
// Sequencer for the onset detector: clear pass, read, divide, update, output.
// Depends on sgod_pkg.
`default_nettype none
module sgod_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sgod_pkg::cmd_type     cmd,
   input  wire sgod_pkg::sts_type sts
);
   import sgod_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (sts.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_READ;
         ST_READ:   state_in = ST_DIV;
         ST_DIV:    if (sts.div_done) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_OUT;
         ST_OUT:    if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear_step = 1'b1;
         ST_IDLE:   begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         ST_READ:   cmd.div_start = 1'b1;
         ST_DIV:    ;
         ST_UPDATE: cmd.update = 1'b1;
         ST_OUT:    rsp_valid = 1'b1;
         default:   ;
      endcase
   end
endmodule
`default_nettype wire

@@ design/sgod_dp.sv @@
// Datapath: mask stores, restoring divider, sums and attack decision.
// Depends on sgod_pkg and sgod_ram.
`default_nettype none
module sgod_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sgod_pkg::cmd_type               cmd,
   output sgod_pkg::sts_type                    sts,
   input  wire logic                            csr_we,
   input  wire logic [sgod_pkg::CsrIdxW-1:0]    csr_index,
   input  wire logic [sgod_pkg::CsrDataW-1:0]   csr_wdata,
   input  wire logic [31:0]                     req_band_energy,
   input  wire logic                            req_is_last_band,
   output logic      [5:0]                      rsp_band_number,
   output logic      [23:0]                     rsp_band_growth,
   output logic                                 rsp_frame_done,
   output logic      [29:0]                     rsp_total_growth,
   output logic                                 rsp_attack
);
   import sgod_pkg::*;

   logic [30:0] lo_ff;
   logic [29:0] hi_ff;
   logic [31:0] emin_ff;
   logic [5:0]  first_ff, lastb_ff;
   logic [7:0]  hold_ff, decay_ff;
   logic [15:0] deb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= 31'd12288; hi_ff <= 30'd28672; emin_ff <= 32'd65536;
         first_ff <= 6'd0; lastb_ff <= 6'd63; hold_ff <= 8'd4;
         decay_ff <= 8'd179; deb_ff <= 16'd7;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LO_THRESH:  lo_ff <= csr_wdata[30:0];
            CSR_HI_THRESH:  hi_ff <= csr_wdata[29:0];
            CSR_MIN_ENERGY: emin_ff <= csr_wdata;
            CSR_FIRST_BAND: first_ff <= csr_wdata[5:0];
            CSR_LAST_BAND:  lastb_ff <= csr_wdata[5:0];
            CSR_HOLD:       hold_ff <= csr_wdata[7:0];
            CSR_DECAY:      decay_ff <= csr_wdata[7:0];
            CSR_DEBOUNCE:   deb_ff <= csr_wdata[15:0];
            default:        ;
         endcase
      end
   end

   logic [BandW-1:0] clr_ff, pos_ff, addr;
   logic [31:0] e_ff;
   logic        last_ff;
   logic [31:0] mask_rd, mask_wd;
   logic [7:0]  hcnt_rd, hcnt_wd;
   logic        mem_we;

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         e_ff <= req_band_energy;
         last_ff <= req_is_last_band;
      end
   end

   assign addr = cmd.clear_step ? clr_ff : pos_ff;

   sgod_ram #(.Width(32), .Depth(MaxBands)) u_mask (
      .clock(clock), .wr_en(mem_we), .addr(addr), .wr_data(mask_wd), .rd_data(mask_rd));
   sgod_ram #(.Width(8), .Depth(MaxBands)) u_hold (
      .clock(clock), .wr_en(mem_we), .addr(addr), .wr_data(hcnt_wd), .rd_data(hcnt_rd));

   // restoring divide: (E<<12) / (M+1), 44-bit quotient, 1 bit per cycle
   logic [43:0] quo_ff;
   logic [32:0] rem_ff, den_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [33:0] trial;

   assign trial = {rem_ff, quo_ff[43]} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else if (cmd.div_start) busy_ff <= 1'b1;
      else if (busy_ff && cnt_ff == 6'd43) busy_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= {e_ff, 12'd0};
         rem_ff <= '0;
         den_ff <= {1'b0, mask_rd} + 33'd1;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (!trial[33]) begin
            rem_ff <= trial[32:0];
            quo_ff <= {quo_ff[42:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[31:0], quo_ff[43]};
            quo_ff <= {quo_ff[42:0], 1'b0};
         end
      end
   end
   assign sts = '{clear_last: (clr_ff == BandW'(MaxBands - 1)),
                  div_done: (busy_ff && cnt_ff == 6'd43)};

   logic        grow;
   logic [43:0] qm1;
   logic [23:0] g;
   assign grow = e_ff > mask_rd;
   assign qm1 = quo_ff - 44'd4096;
   assign g = !grow ? 24'd0 : (|qm1[43:24] ? 24'hFFFFFF : qm1[23:0]);

   logic [7:0]  dec;
   logic [39:0] prod;
   logic [7:0]  hinc;
   assign dec = decay_ff < 8'd13 ? 8'd13 : (decay_ff > 8'd243 ? 8'd243 : decay_ff);
   assign prod = mask_rd * dec;
   assign hinc = hcnt_rd == 8'hFF ? hcnt_rd : hcnt_rd + 8'd1;

   always_comb begin
      mem_we = cmd.clear_step | cmd.update;
      mask_wd = '0;
      hcnt_wd = '0;
      if (cmd.update) begin
         if (grow) mask_wd = e_ff;
         else begin
            hcnt_wd = hinc;
            mask_wd = hinc >= hold_ff ? prod[39:8] : mask_rd;
         end
      end
   end

   logic [29:0] gsum_ff, prev_ff;
   logic [37:0] esum_ff;
   logic        pend_ff;
   logic [15:0] dl_ff;
   logic [30:0] gs_add;
   logic [29:0] gsum_n;
   logic [38:0] es_add;
   logic [37:0] esum_n;
   logic        counted, arm, rel_t, rel_d, lo_neg;

   assign counted = pos_ff >= first_ff && pos_ff <= lastb_ff && g != 0;
   assign gs_add = {1'b0, gsum_ff} + {7'd0, g};
   assign gsum_n = !counted ? gsum_ff : (gs_add[30] ? 30'h3FFFFFFF : gs_add[29:0]);
   assign es_add = {1'b0, esum_ff} + {7'd0, e_ff};
   assign esum_n = es_add[38] ? '1 : es_add[37:0];
   assign lo_neg = lo_ff[30];
   assign arm = esum_n >= {6'd0, emin_ff} && gsum_n > hi_ff && !pend_ff && dl_ff == 0;
   assign rel_t = pend_ff && !lo_neg && lo_ff != 0 && {1'b0, gsum_n} < lo_ff;
   assign rel_d = pend_ff && lo_neg && gsum_n < prev_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_step) begin
         pos_ff <= '0; gsum_ff <= '0; esum_ff <= '0; prev_ff <= '0;
         pend_ff <= 1'b0; dl_ff <= '0;
      end else if (cmd.update) begin
         if (last_ff) begin
            if (arm) begin
               pend_ff <= 1'b1;
               dl_ff <= deb_ff;
            end else begin
               if (rel_t || rel_d) pend_ff <= 1'b0;
               if (dl_ff != 0) dl_ff <= dl_ff - 16'd1;
            end
            prev_ff <= gsum_n;
            pos_ff <= '0; gsum_ff <= '0; esum_ff <= '0;
         end else begin
            pos_ff <= pos_ff + 1'b1;
            gsum_ff <= gsum_n; esum_ff <= esum_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_band_number <= 6'(pos_ff);
         rsp_band_growth <= g;
         rsp_frame_done <= last_ff;
         rsp_total_growth <= last_ff ? gsum_n : 30'd0;
         rsp_attack <= last_ff && !arm && (rel_t || rel_d);
      end
   end
endmodule
`default_nettype wire

@@ design/spectral_growth_onset_detector_core.sv @@
// Top level of the spectral growth onset detector.
// Depends on sgod_pkg, sgod_ctrl, sgod_dp.
//
// A band beat is accepted only while the core is idle. Its result passes through
// one RAM read, a 44-step restoring divider (one quotient bit per cycle) and one
// update step before it is presented. The next beat is accepted only once the
// result has been taken. After reset a clearing pass zeroes the mask and hold
// stores; no beat is accepted during it. CSR writes are taken any time.
`default_nettype none
module spectral_growth_onset_detector_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [31:0]                        req_band_energy,
   input  wire logic                               req_is_last_band,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [5:0]                              rsp_band_number,
   output logic [23:0]                             rsp_band_growth,
   output logic                                    rsp_frame_done,
   output logic [29:0]                             rsp_total_growth,
   output logic                                    rsp_attack,
   input  wire logic                               csr_we,
   input  wire logic [sgod_pkg::CsrIdxW-1:0]       csr_index,
   input  wire logic [sgod_pkg::CsrDataW-1:0]      csr_wdata
);
   import sgod_pkg::*;
   cmd_type cmd;
   sts_type sts;

   sgod_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd), .sts(sts));

   sgod_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_band_energy(req_band_energy), .req_is_last_band(req_is_last_band),
      .rsp_band_number(rsp_band_number), .rsp_band_growth(rsp_band_growth),
      .rsp_frame_done(rsp_frame_done), .rsp_total_growth(rsp_total_growth),
      .rsp_attack(rsp_attack));
endmodule
`default_nettype wire

@@ design/sgod_checker.sv @@
// Port-level checks for the onset detector core.
// Depends on spectral_growth_onset_detector_core.
`default_nettype none
module sgod_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_frame_done,
   input wire logic [29:0] rsp_total_growth,
   input wire logic        rsp_attack
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_total_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_total_growth == 0 && !rsp_attack)
      else $error("frame fields outside frame end");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_growth))
      else $error("result dropped");
   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("back-to-back accept");
endmodule

bind spectral_growth_onset_detector_core sgod_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_frame_done(rsp_frame_done),
   .rsp_total_growth(rsp_total_growth), .rsp_attack(rsp_attack));
`default_nettype wire

@@ sim/tb_spectral_growth_onset_detector_core.sv @@
// Testbench for the spectral growth onset detector core: directed table plus random frames,
// every result beat checked against a band-level growth and onset predictor.
// Depends on sgod_pkg and spectral_growth_onset_detector_core.
`default_nettype none
module tb_spectral_growth_onset_detector_core;
   import sgod_pkg::*;

   typedef struct packed {
      logic [5:0]  band;
      logic [23:0] growth;
      logic        done;
      logic [29:0] total;
      logic        attack;
   } band_result_t;

   typedef struct {
      logic [31:0] energy;
      logic        last;
      logic        known;
      band_result_t want;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_band_energy = '0;
   logic req_is_last_band = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [5:0] rsp_band_number;
   logic [23:0] rsp_band_growth;
   logic rsp_frame_done;
   logic [29:0] rsp_total_growth;
   logic rsp_attack;
   logic csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   spectral_growth_onset_detector_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_band_energy(req_band_energy), .req_is_last_band(req_is_last_band),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_band_number(rsp_band_number), .rsp_band_growth(rsp_band_growth),
      .rsp_frame_done(rsp_frame_done), .rsp_total_growth(rsp_total_growth),
      .rsp_attack(rsp_attack),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [30:0] p_lo;
   logic [29:0] p_hi;
   logic [31:0] p_min_energy;
   logic [5:0]  p_first, p_last;
   logic [7:0]  p_hold, p_decay;
   logic [15:0] p_debounce;
   logic [31:0] mask_lvl [MaxBands];
   logic [7:0]  hold_cnt [MaxBands];
   logic [5:0]  pos;
   logic [29:0] gsum, prev_gsum;
   logic [37:0] esum;
   logic        pending;
   logic [15:0] deb_left;

   band_result_t expected_results[$];
   int errors = 0;
   int n_beats = 0;
   int n_attacks = 0;
   int n_frames = 0;
   bit quiet = 1'b0;
   int req_idle_max = 19;

   task automatic predictor_reset();
      p_lo = 31'd12288; p_hi = 30'd28672; p_min_energy = 32'd65536;
      p_first = 6'd0; p_last = 6'd63; p_hold = 8'd4; p_decay = 8'd179;
      p_debounce = 16'd7;
      for (int i = 0; i < MaxBands; i++) begin
         mask_lvl[i] = '0;
         hold_cnt[i] = '0;
      end
      pos = '0; gsum = '0; prev_gsum = '0; esum = '0; pending = 1'b0; deb_left = '0;
   endtask

   function automatic logic [23:0] growth_of(logic [31:0] e, logic [31:0] m);
      logic [63:0] q;
      if (e <= m) return 24'd0;
      q = ({32'd0, e} << 12) / ({32'd0, m} + 64'd1) - 64'd4096;
      return (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
   endfunction

   function automatic band_result_t predict_band(logic [31:0] e, logic last);
      band_result_t r;
      logic [31:0] m;
      logic [23:0] g;
      logic [30:0] s;
      logic [38:0] es;
      logic [7:0] dec;
      logic [39:0] prod;
      logic armed;
      m = mask_lvl[pos];
      g = growth_of(e, m);
      if (pos >= p_first && pos <= p_last && g != 0) begin
         s = {1'b0, gsum} + {7'd0, g};
         gsum = (s > 31'h3FFFFFFF) ? 30'h3FFFFFFF : s[29:0];
      end
      es = {1'b0, esum} + {7'd0, e};
      esum = (es > 39'h3FFFFFFFFF) ? 38'h3FFFFFFFFF : es[37:0];
      dec = (p_decay < 8'd13) ? 8'd13 : ((p_decay > 8'd243) ? 8'd243 : p_decay);
      if (e > m) begin
         mask_lvl[pos] = e;
         hold_cnt[pos] = '0;
      end else begin
         if (hold_cnt[pos] != 8'd255) hold_cnt[pos] = hold_cnt[pos] + 8'd1;
         if (hold_cnt[pos] >= p_hold) begin
            prod = m * dec;
            mask_lvl[pos] = prod[39:8];
         end
      end
      r.band = pos; r.growth = g; r.done = last; r.total = '0; r.attack = 1'b0;
      if (last) begin
         armed = 1'b0;
         r.total = gsum;
         if (esum >= {6'd0, p_min_energy} && gsum > p_hi && !pending && deb_left == 0) begin
            pending = 1'b1;
            deb_left = p_debounce;
            armed = 1'b1;
         end else if (pending && !p_lo[30] && p_lo != 0 && {1'b0, gsum} < p_lo) begin
            pending = 1'b0;
            r.attack = 1'b1;
         end else if (pending && p_lo[30] && gsum < prev_gsum) begin
            pending = 1'b0;
            r.attack = 1'b1;
         end
         if (!armed && deb_left != 0) deb_left = deb_left - 16'd1;
         prev_gsum = gsum;
         pos = '0; gsum = '0; esum = '0;
      end else begin
         pos = pos + 6'd1;
      end
      return r;
   endfunction

   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LO_THRESH:  p_lo = val[30:0];
         CSR_HI_THRESH:  p_hi = val[29:0];
         CSR_MIN_ENERGY: p_min_energy = val;
         CSR_FIRST_BAND: p_first = val[5:0];
         CSR_LAST_BAND:  p_last = val[5:0];
         CSR_HOLD:       p_hold = val[7:0];
         CSR_DECAY:      p_decay = val[7:0];
         default:        p_debounce = val[15:0];
      endcase
   endtask

   task automatic send_beat(logic [31:0] e, logic last, logic known, band_result_t want);
      band_result_t r;
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, req_idle_max);
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_valid <= 1'b1; req_band_energy <= e; req_is_last_band <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = predict_band(e, last);
      if (known && r !== want) begin
         $display("%0t directed row disagrees with predictor: typed %h predicted %h",
                  $time, want, r);
         errors++;
      end
      expected_results.push_back(r);
      n_beats++;
      if (last) n_frames++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic random_frame(int nb);
      logic [31:0] e;
      for (int b = 0; b < nb; b++) begin
         case ($urandom_range(0, 5))
            0: e = $urandom;
            1: e = $urandom_range(0, 255);
            2: e = {16'd0, 16'($urandom)};
            default: e = $urandom_range(0, 32'h0040_0000);
         endcase
         send_beat(e, b == nb - 1, 1'b0, '0);
      end
   endtask

   // result side
   int stall_left = 0;
   always @(negedge clock) begin
      if (quiet) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      band_result_t got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_band_number, rsp_band_growth, rsp_frame_done, rsp_total_growth,
                 rsp_attack};
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result beat %h", $time, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got.attack) n_attacks++;
            if (got.band !== want.band) begin
               $display("%0t band_number exp %0d got %0d", $time, want.band, got.band);
               errors++;
            end
            if (got.growth !== want.growth) begin
               $display("%0t band_growth exp %h got %h", $time, want.growth, got.growth);
               errors++;
            end
            if (got.done !== want.done) begin
               $display("%0t frame_done exp %b got %b", $time, want.done, got.done);
               errors++;
            end
            if (got.total !== want.total) begin
               $display("%0t total_growth exp %h got %h", $time, want.total, got.total);
               errors++;
            end
            if (got.attack !== want.attack) begin
               $display("%0t attack exp %b got %b", $time, want.attack, got.attack);
               errors++;
            end
         end
      end
   end

   initial begin
      #20000000;
      $display("TEST FAILED");
      $finish;
   end

   stim_row_t dir_rows[$];

   initial begin
      stim_row_t row;
      predictor_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty mask gives e*4096-4096 saturated; zero energy gives zero
      row = '{32'd0, 1'b0, 1'b1, '{6'd0, 24'd0, 1'b0, 30'd0, 1'b0}};
      dir_rows.push_back(row);
      row = '{32'd1, 1'b0, 1'b1, '{6'd1, 24'd0, 1'b0, 30'd0, 1'b0}};
      dir_rows.push_back(row);
      row = '{32'd2, 1'b0, 1'b1, '{6'd2, 24'd4096, 1'b0, 30'd0, 1'b0}};
      dir_rows.push_back(row);
      row = '{32'hFFFFFFFF, 1'b0, 1'b1, '{6'd3, 24'hFFFFFF, 1'b0, 30'd0, 1'b0}};
      dir_rows.push_back(row);
      row = '{32'hAAAA5555, 1'b1, 1'b0, '0};
      dir_rows.push_back(row);
      for (int i = 0; i < 6; i++) begin
         row = '{32'h5555AAAA >> i, i == 5, 1'b0, '0};
         dir_rows.push_back(row);
      end
      for (int i = 0; i < 4; i++) begin
         row = '{32'd0, i == 3, 1'b0, '0};
         dir_rows.push_back(row);
      end
      foreach (dir_rows[i])
         send_beat(dir_rows[i].energy, dir_rows[i].last, dir_rows[i].known,
                   dir_rows[i].want);
      wait_drained();

      // band wrap without last-band mark
      for (int b = 0; b < 70; b++) send_beat($urandom, b == 69, 1'b0, '0);
      wait_drained();

      // config sweep, extremes included
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               csr_write(CSR_LO_THRESH, 32'h7FFFFFFF);
               csr_write(CSR_HI_THRESH, 32'd0);
               csr_write(CSR_MIN_ENERGY, 32'd0);
               csr_write(CSR_DEBOUNCE, 32'd0);
               csr_write(CSR_DECAY, 32'd0);
               csr_write(CSR_HOLD, 32'd0);
            end
            1: begin
               csr_write(CSR_LO_THRESH, 32'd0);
               csr_write(CSR_HI_THRESH, 32'h3FFFFFFF);
               csr_write(CSR_MIN_ENERGY, 32'hFFFFFFFF);
               csr_write(CSR_FIRST_BAND, 32'd63);
               csr_write(CSR_LAST_BAND, 32'd0);
               csr_write(CSR_HOLD, 32'd255);
               csr_write(CSR_DECAY, 32'd255);
               csr_write(CSR_DEBOUNCE, 32'hFFFF);
            end
            2: begin
               csr_write(CSR_LO_THRESH, 32'h3FFFFFFF);
               csr_write(CSR_HI_THRESH, 32'd4096);
               csr_write(CSR_MIN_ENERGY, 32'd1000);
               csr_write(CSR_FIRST_BAND, 32'd1);
               csr_write(CSR_LAST_BAND, 32'd5);
               csr_write(CSR_DEBOUNCE, 32'd2);
               csr_write(CSR_DECAY, 32'd13);
               csr_write(CSR_HOLD, 32'd1);
            end
            default: begin
               csr_write(CSR_LO_THRESH, ($urandom_range(0, 2) == 0) ? 32'h7FFFFFFF
                         : $urandom_range(0, 32'h0010_0000));
               csr_write(CSR_HI_THRESH, $urandom_range(0, 32'h0008_0000));
               csr_write(CSR_MIN_ENERGY, $urandom_range(0, 32'h0100_0000));
               csr_write(CSR_FIRST_BAND, $urandom_range(0, 7));
               csr_write(CSR_LAST_BAND, $urandom_range(4, 63));
               csr_write(CSR_HOLD, $urandom_range(0, 6));
               csr_write(CSR_DECAY, $urandom_range(0, 255));
               csr_write(CSR_DEBOUNCE, $urandom_range(0, 4));
            end
         endcase
         while (n_beats < 60 + (ph + 1) * 120) begin
            random_frame($urandom_range(1, 10));
            if (ph == 7 && n_beats > 700) quiet = 1'b1;
         end
         wait_drained();
      end

      quiet = 1'b1;
      while (n_beats < 1070) random_frame($urandom_range(1, 8));
      wait_drained();

      $display("Covered %0d band beats in %0d frames, %0d attacks reported.",
               n_beats, n_frames, n_attacks);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
